@@ design/circular_fifo_queue_assert.svh @@
// Assertion macros used by the checker file of the queue.
`ifndef CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CFQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// Next-cycle implication, disabled while reset is asserted
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

@@ design/cfq_pkg.sv @@
package cfq_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    // operation codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] oldest_value;
        logic signed [WORD_W-1:0] newest_value;
        logic                     is_empty;
        logic                     is_full;
    } rsp_t;

    // per-cycle command broadcast to every storage cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WORD_W-1:0] value;
    } ctl_t;

endpackage

@@ design/circular_fifo_queue.sv @@
// A result is loaded into the result register in the cycle after its request is taken.
// Throughput: one push or pop per cycle; the request side stalls only while a
// finished result is held in the result register and the result side stalls.
// Storage is a row of DEPTH-1 cells; a pop shifts every cell toward the head.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending result.
module circular_fifo_queue #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cfq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cfq_pkg::rsp_t rsp
);
    import cfq_pkg::*;

    localparam int N = DEPTH - 1;

    logic [N-1:0]      cell_valid;
    logic [WORD_W-1:0] cell_data [N];
    logic [N-1:0]      right_valid;
    logic [WORD_W-1:0] right_data [N];
    logic [N-1:0]      left_valid;
    logic [N+1:0]      occ;
    ctl_t              ctl;

    logic              accept;
    logic              is_push;
    logic              was_full;
    logic              was_empty;
    logic              do_push;
    logic              do_pop;

    logic [WORD_W-1:0] newest_reg;
    logic [WORD_W-1:0] newest_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    // occ[k] is set when the queue holds at least k entries
    assign occ       = {1'b0, cell_valid, 1'b1};
    assign was_empty = !occ[1];
    assign was_full  = occ[N];

    // handshake
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign is_push   = (req.kind == KIND_PUSH);
    assign do_push   = accept && is_push && !was_full;
    assign do_pop    = accept && !is_push && !was_empty;

    assign ctl.push  = do_push;
    assign ctl.pop   = do_pop;
    assign ctl.value = req.push_value;

    // neighbor wiring of the cell row
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            left_valid[i] = occ[i];
            if (i == N - 1)
            begin
                right_valid[i] = 1'b0;
                right_data[i]  = '0;
            end
            else
            begin
                right_valid[i] = cell_valid[i+1];
                right_data[i]  = cell_data[i+1];
            end
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        cfq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_valid  (left_valid[g]),
            .right_valid (right_valid[g]),
            .right_data  (right_data[g]),
            .valid       (cell_valid[g]),
            .data        (cell_data[g])
        );
    end

    // last pushed word is the newest entry while the queue is not empty
    assign newest_next = do_push ? req.push_value : newest_reg;

    always_ff @(posedge clk)
    begin
        newest_reg <= newest_next;
    end

    // result for the state after the transaction
    always_comb
    begin
        rsp_next = '0;
        if (do_push)
        begin
            rsp_next.status       = ST_DONE;
            rsp_next.is_empty     = 1'b0;
            rsp_next.is_full      = occ[N-1];
            rsp_next.oldest_value = was_empty ? req.push_value : cell_data[0];
            rsp_next.newest_value = req.push_value;
        end
        else if (do_pop)
        begin
            rsp_next.status       = ST_DONE;
            rsp_next.is_empty     = !occ[2];
            rsp_next.is_full      = 1'b0;
            rsp_next.oldest_value = occ[2] ? right_data[0] : '0;
            rsp_next.newest_value = occ[2] ? newest_reg : '0;
        end
        else
        begin
            rsp_next.status       = is_push ? ST_FULL : ST_EMPTY;
            rsp_next.is_empty     = was_empty;
            rsp_next.is_full      = was_full;
            rsp_next.oldest_value = was_empty ? '0 : cell_data[0];
            rsp_next.newest_value = was_empty ? '0 : newest_reg;
        end
    end

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ design/cfq_cell.sv @@
module cfq_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfq_pkg::ctl_t               ctl,
    input  logic                        left_valid,
    input  logic                        right_valid,
    input  logic [cfq_pkg::WORD_W-1:0]  right_data,
    output logic                        valid,
    output logic [cfq_pkg::WORD_W-1:0]  data
);
    import cfq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              load_push;

    // a push lands in the first free cell: the one whose left neighbor is occupied
    assign load_push = ctl.push && left_valid && !valid_reg;

    // pop shifts the whole row one cell toward the head
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.pop)
        begin
            valid_next = right_valid;
            data_next  = right_data;
        end
        else if (load_push)
        begin
            valid_next = 1'b1;
            data_next  = ctl.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ design/cfq_checker.sv @@
`include "circular_fifo_queue_assert.svh"

module cfq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input cfq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cfq_pkg::rsp_t rsp
);
    import cfq_pkg::*;

    // every accepted transaction leaves a result behind
    `CFQ_ASSERT_NEXT(a_req_gives_rsp, clk, rst_n, req_valid && !req_stall, rsp_valid)

    // an empty queue reports both values as zero
    `CFQ_ASSERT_NOW(a_empty_zero, clk, rst_n, rsp_valid && rsp.is_empty, rsp.oldest_value == 0 && rsp.newest_value == 0)

    // empty and full never together
    `CFQ_ASSERT_NOW(a_not_both, clk, rst_n, rsp_valid, !(rsp.is_empty && rsp.is_full))

    // a rejection matches the flag that caused it
    `CFQ_ASSERT_NOW(a_reject_flag, clk, rst_n, rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY), (rsp.status == ST_FULL && rsp.is_full) || (rsp.status == ST_EMPTY && rsp.is_empty))

    // a stalled result holds
    `CFQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (.*);
